// ===== src/radix_string_to_integer_defines.svh =====
// assertion macros shared by the radix string parser modules
// needs nothing else; files that check their own logic include it
`ifndef RADIX_STRING_TO_INTEGER_DEFINES_SVH
`define RADIX_STRING_TO_INTEGER_DEFINES_SVH

// condition must hold at every edge out of reset
`define RSTI_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define RSTI_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RSTI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rsti_pkg.sv =====
// types and constants for the radix string parser
// used by the front, queue, back and top level; depends on nothing
package rsti_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int POS_W       = $clog2(MAX_LEN + 1);
    localparam int BASE_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 64;
    localparam int OFFSET_W    = 13;
    localparam int ACC_W       = VALUE_W + BASE_W + 1;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [VALUE_W-1:0] MAG_LIMIT = {1'b0, {(VALUE_W-1){1'b1}}};

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    localparam logic [5:0] DIGIT_NONE   = 6'd63;
    localparam logic [5:0] LETTER_FIRST = 6'd10;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // one classified character as it crosses the queue
    typedef struct packed {
        logic              is_space;
        logic              is_plus;
        logic              is_minus;
        logic              is_zero;
        logic              is_x;
        logic [5:0]        digit;
        logic              in_range;
        logic              first;
        logic              is_last;
        logic [BASE_W-1:0] base;
        logic [POS_W-1:0]  pos;
    } entry_t;

endpackage

// ===== src/rsti_front.sv =====
// front end: radix register, character classification and position count
// depends on rsti_pkg
module rsti_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rsti_pkg::BASE_W-1:0]   cfg_radix,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rsti_pkg::CHAR_W-1:0]   s_char_code,
    input  logic                          s_is_last,
    input  logic                          q_full,
    output logic                          q_push,
    output rsti_pkg::entry_t              q_data
);

    logic [rsti_pkg::BASE_W-1:0] radix_reg;
    logic [rsti_pkg::POS_W-1:0]  pos_reg;
    logic [rsti_pkg::POS_W-1:0]  pos_next;
    logic                        in_range;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign q_push    = s_valid && s_ready;
    assign in_range  = pos_reg < rsti_pkg::POS_W'(rsti_pkg::MAX_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= rsti_pkg::BASE_AUTO;
        end else if (cfg_valid && cfg_ready) begin
            radix_reg <= cfg_radix;
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (q_push) begin
            if (s_is_last) begin
                pos_next = '0;
            end else if (in_range) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_comb begin
        q_data          = '0;
        q_data.is_space = (s_char_code == rsti_pkg::CH_SPACE) ||
                          (s_char_code >= rsti_pkg::CH_TAB && s_char_code <= rsti_pkg::CH_CR);
        q_data.is_plus  = s_char_code == rsti_pkg::CH_PLUS;
        q_data.is_minus = s_char_code == rsti_pkg::CH_MINUS;
        q_data.is_zero  = s_char_code == rsti_pkg::CH_ZERO;
        q_data.is_x     = (s_char_code == rsti_pkg::CH_LX) || (s_char_code == rsti_pkg::CH_UX);
        // raw digit value regardless of base; the back end compares it with the base
        priority if (s_char_code >= rsti_pkg::CH_ZERO && s_char_code <= rsti_pkg::CH_NINE) begin
            q_data.digit = 6'(s_char_code - rsti_pkg::CH_ZERO);
        end else if (s_char_code >= rsti_pkg::CH_LA && s_char_code <= rsti_pkg::CH_LZ) begin
            q_data.digit = 6'(s_char_code - rsti_pkg::CH_LA) + rsti_pkg::LETTER_FIRST;
        end else if (s_char_code >= rsti_pkg::CH_UA && s_char_code <= rsti_pkg::CH_UZ) begin
            q_data.digit = 6'(s_char_code - rsti_pkg::CH_UA) + rsti_pkg::LETTER_FIRST;
        end else begin
            q_data.digit = rsti_pkg::DIGIT_NONE;
        end
        q_data.in_range = in_range;
        q_data.first    = pos_reg == '0;
        q_data.is_last  = s_is_last;
        q_data.base     = (radix_reg > rsti_pkg::BASE_MAX) ? rsti_pkg::BASE_MAX : radix_reg;
        q_data.pos      = pos_reg;
    end

endmodule

// ===== src/rsti_fifo.sv =====
// short queue of classified characters between front and back end
// depends on rsti_pkg and the shared assertion macros
`include "radix_string_to_integer_defines.svh"

module rsti_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rsti_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output rsti_pkg::entry_t pop_data
);

    localparam int PTR_W = (rsti_pkg::FIFO_DEPTH > 1) ? $clog2(rsti_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(rsti_pkg::FIFO_DEPTH + 1);

    rsti_pkg::entry_t   slot_reg [rsti_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = count_reg == CNT_W'(rsti_pkg::FIFO_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(rsti_pkg::FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(rsti_pkg::FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    `RSTI_ASSERT_ALWAYS(a_count_in_range, aclk, aresetn, count_reg <= CNT_W'(rsti_pkg::FIFO_DEPTH), "queue count beyond depth")
    `RSTI_ASSERT_IMPLIES(a_no_push_full, aclk, aresetn, push, !full, "push into full queue")
    `RSTI_ASSERT_IMPLIES(a_no_pop_empty, aclk, aresetn, pop, pop_valid, "pop from empty queue")

endmodule

// ===== src/rsti_back.sv =====
// back end: sign/prefix/digit sequencer, multiply-accumulate and result register
// depends on rsti_pkg and the shared assertion macros
`include "radix_string_to_integer_defines.svh"

module rsti_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            e_valid,
    input  rsti_pkg::entry_t                e_data,
    output logic                            e_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [rsti_pkg::VALUE_W-1:0]  m_value,
    output logic [rsti_pkg::OFFSET_W-1:0]   m_stop_offset,
    output logic                            m_overflow
);

    rsti_pkg::phase_t              phase_reg, phase_next;
    logic [rsti_pkg::VALUE_W-1:0]  mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic                          sat_reg, sat_next;
    logic [rsti_pkg::BASE_W-1:0]   wb_reg, wb_next;
    logic [rsti_pkg::POS_W-1:0]    stop_reg, stop_next;

    logic                          out_valid_reg;
    logic [rsti_pkg::VALUE_W-1:0]  out_mag_reg;
    logic                          out_neg_reg;
    logic [rsti_pkg::POS_W-1:0]    out_stop_reg;
    logic                          out_sat_reg;

    logic                          out_free;
    logic                          take_last;
    logic [rsti_pkg::BASE_W-1:0]   wb_cur;
    logic [rsti_pkg::BASE_W-1:0]   eff_base;
    logic                          do_digit;
    logic                          digit_ok;
    logic [rsti_pkg::ACC_W-1:0]    acc;
    logic                          acc_over;
    logic [rsti_pkg::POS_W-1:0]    pos_inc;

    assign out_free  = !out_valid_reg || m_ready;
    assign e_pop     = e_valid && (!e_data.is_last || out_free);
    assign take_last = e_pop && e_data.is_last;
    assign wb_cur    = e_data.first ? e_data.base : wb_reg;
    assign pos_inc   = e_data.pos + 1'b1;

    // base after any prefix decision, auto falls back to decimal
    assign eff_base  = (wb_next == rsti_pkg::BASE_AUTO) ? rsti_pkg::BASE_DEC : wb_next;
    assign digit_ok  = e_data.digit < eff_base;
    assign acc       = rsti_pkg::ACC_W'(mag_reg) * rsti_pkg::ACC_W'(eff_base) +
                       rsti_pkg::ACC_W'(e_data.digit);
    assign acc_over  = |acc[rsti_pkg::ACC_W-1:rsti_pkg::VALUE_W-1];

    always_comb begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        wb_next    = wb_reg;
        stop_next  = stop_reg;
        do_digit   = 1'b0;

        if (e_pop && e_data.in_range) begin
            wb_next = wb_cur;
            unique case (phase_reg)
                rsti_pkg::PH_SPACE, rsti_pkg::PH_SIGNED: begin
                    if (phase_reg == rsti_pkg::PH_SPACE && e_data.is_space) begin
                        stop_next = pos_inc;
                    end else if (phase_reg == rsti_pkg::PH_SPACE &&
                                 (e_data.is_plus || e_data.is_minus)) begin
                        neg_next   = e_data.is_minus;
                        stop_next  = pos_inc;
                        phase_next = rsti_pkg::PH_SIGNED;
                    end else if ((wb_cur == rsti_pkg::BASE_AUTO || wb_cur == rsti_pkg::BASE_HEX)
                                 && e_data.is_zero) begin
                        phase_next = rsti_pkg::PH_ZERO;
                        stop_next  = pos_inc;
                    end else begin
                        if (wb_cur == rsti_pkg::BASE_AUTO) begin
                            wb_next = rsti_pkg::BASE_DEC;
                        end
                        phase_next = rsti_pkg::PH_DIGITS;
                        do_digit   = 1'b1;
                    end
                end
                rsti_pkg::PH_ZERO: begin
                    if (e_data.is_x) begin
                        wb_next    = rsti_pkg::BASE_HEX;
                        phase_next = rsti_pkg::PH_DIGITS;
                        stop_next  = pos_inc;
                    end else begin
                        if (wb_cur == rsti_pkg::BASE_AUTO) begin
                            wb_next = rsti_pkg::BASE_DEC;
                        end
                        phase_next = rsti_pkg::PH_DIGITS;
                        do_digit   = 1'b1;
                    end
                end
                rsti_pkg::PH_DIGITS: begin
                    do_digit = 1'b1;
                end
                default: begin
                end
            endcase

            if (do_digit) begin
                if (!digit_ok) begin
                    phase_next = rsti_pkg::PH_DONE;
                end else begin
                    // once saturated further digits are consumed but the value sticks
                    if (sat_reg || acc_over) begin
                        sat_next = 1'b1;
                        mag_next = rsti_pkg::MAG_LIMIT;
                    end else begin
                        mag_next = acc[rsti_pkg::VALUE_W-1:0];
                    end
                    stop_next = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rsti_pkg::PH_SPACE;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            wb_reg    <= rsti_pkg::BASE_AUTO;
            stop_reg  <= '0;
        end else if (take_last) begin
            phase_reg <= rsti_pkg::PH_SPACE;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            wb_reg    <= rsti_pkg::BASE_AUTO;
            stop_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            sat_reg   <= sat_next;
            wb_reg    <= wb_next;
            stop_reg  <= stop_next;
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_last) begin
            out_mag_reg  <= mag_next;
            out_neg_reg  <= neg_next;
            out_stop_reg <= stop_next;
            out_sat_reg  <= sat_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_value       = out_neg_reg ? -$signed(out_mag_reg) : $signed(out_mag_reg);
    assign m_stop_offset = rsti_pkg::OFFSET_W'(out_stop_reg);
    assign m_overflow    = out_sat_reg;

    `RSTI_ASSERT_IMPLIES(a_sat_pins_limit, aclk, aresetn, sat_reg, mag_reg == rsti_pkg::MAG_LIMIT, "saturated magnitude off limit")
    `RSTI_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, take_last, phase_reg == rsti_pkg::PH_SPACE && mag_reg == '0, "state not cleared after end mark")
    `RSTI_ASSERT_ALWAYS(a_stop_bounded, aclk, aresetn, stop_reg <= rsti_pkg::POS_W'(rsti_pkg::MAX_LEN), "stop offset past string limit")

endmodule

// ===== src/radix_string_to_integer.sv =====
// Streaming strtol-style parser: one character per beat on s_, the beat with
// s_is_last set ends the string and yields exactly one beat on m_ (signed
// value saturated to +/-(2^63-1), offset of the first unconsumed character,
// overflow flag). Sustained rate is one character per clock, bounded by the
// back end's 64x6 multiply-accumulate loop, while m_ does not stall; the
// result passes the queue and the back end's result register on to m_. The
// radix (0 = auto, 1..36, above 36 taken as 36) is sampled at the first
// character of each string. Characters beyond 4096 are ignored.
// depends on rsti_pkg, rsti_front, rsti_fifo and rsti_back
module radix_string_to_integer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rsti_pkg::BASE_W-1:0]          cfg_radix,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rsti_pkg::CHAR_W-1:0]          s_char_code,
    input  logic                                 s_is_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [rsti_pkg::VALUE_W-1:0]  m_value,
    output logic [rsti_pkg::OFFSET_W-1:0]        m_stop_offset,
    output logic                                 m_overflow
);

    rsti_pkg::entry_t push_data;
    rsti_pkg::entry_t pop_data;
    logic             push;
    logic             full;
    logic             pop;
    logic             pop_valid;

    rsti_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_radix   (cfg_radix),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_is_last   (s_is_last),
        .q_full      (full),
        .q_push      (push),
        .q_data      (push_data)
    );

    rsti_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    rsti_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .e_valid       (pop_valid),
        .e_data        (pop_data),
        .e_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_stop_offset (m_stop_offset),
        .m_overflow    (m_overflow)
    );

endmodule

// ===== dv/radix_string_to_integer_test.sv =====
// self-checking testbench for radix_string_to_integer: streams character beats,
// predicts each parsed result in a scoreboard class and checks every m_ beat
// depends on rsti_pkg and the radix_string_to_integer rtl
`timescale 1ns / 1ps

module radix_string_to_integer_test;

    typedef struct {
        logic signed [rsti_pkg::VALUE_W-1:0] value;
        logic [rsti_pkg::OFFSET_W-1:0]       offset;
        logic                                overflow;
    } parse_result_t;

    // tracks the parser state and holds the results still owed by the block
    class parse_scoreboard;
        logic [rsti_pkg::BASE_W-1:0]  radix_reg;
        rsti_pkg::phase_t             stage;
        logic [rsti_pkg::VALUE_W-1:0] mag;
        bit                           neg;
        bit                           sat;
        int unsigned                  pos;
        int unsigned                  wbase;
        int unsigned                  stop;
        parse_result_t                pending_values[$];
        int                           errors;

        function new();
            radix_reg = rsti_pkg::BASE_AUTO;
            errors = 0;
            clear_string();
        endfunction

        function void clear_string();
            stage = rsti_pkg::PH_SPACE;
            mag = '0;
            neg = 1'b0;
            sat = 1'b0;
            pos = 0;
            wbase = 0;
            stop = 0;
        endfunction

        function void set_radix(logic [rsti_pkg::BASE_W-1:0] r);
            radix_reg = r;
        endfunction

        task report(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            errors++;
        endtask

        function int digit_value(int code, int unsigned b);
            int zero_c, la_c, ua_c, ib;
            zero_c = int'(rsti_pkg::CH_ZERO);
            la_c = int'(rsti_pkg::CH_LA);
            ua_c = int'(rsti_pkg::CH_UA);
            ib = int'(b);
            if (ib <= 10)
                return (code >= zero_c && code < zero_c + ib) ? code - zero_c : -1;
            if (code >= zero_c && code <= int'(rsti_pkg::CH_NINE))
                return code - zero_c;
            if (code >= la_c && code <= la_c + ib - 11)
                return code - la_c + int'(rsti_pkg::LETTER_FIRST);
            if (code >= ua_c && code <= ua_c + ib - 11)
                return code - ua_c + int'(rsti_pkg::LETTER_FIRST);
            return -1;
        endfunction

        function void digit_step(int code, int unsigned at);
            int unsigned                  b;
            int                           d;
            logic [rsti_pkg::VALUE_W-1:0] dv;
            b = (wbase == 0) ? 10 : wbase;
            d = digit_value(code, b);
            if (d < 0) begin
                stage = rsti_pkg::PH_DONE;
                return;
            end
            dv = rsti_pkg::VALUE_W'(d);
            // saturate once the next digit would push past 2^63-1
            if (sat || mag > (rsti_pkg::MAG_LIMIT - dv) / rsti_pkg::VALUE_W'(b)) begin
                sat = 1'b1;
                mag = rsti_pkg::MAG_LIMIT;
            end else begin
                mag = mag * rsti_pkg::VALUE_W'(b) + dv;
            end
            stop = at + 1;
        endfunction

        function void prefix_step(int code, int unsigned at);
            if ((wbase == 32'(rsti_pkg::BASE_AUTO) || wbase == 32'(rsti_pkg::BASE_HEX)) &&
                code == int'(rsti_pkg::CH_ZERO)) begin
                stage = rsti_pkg::PH_ZERO;
                stop = at + 1;
                return;
            end
            if (wbase == 32'(rsti_pkg::BASE_AUTO))
                wbase = 32'(rsti_pkg::BASE_DEC);
            stage = rsti_pkg::PH_DIGITS;
            digit_step(code, at);
        endfunction

        function void take_char(int code, int unsigned at);
            case (stage)
                rsti_pkg::PH_SPACE: begin
                    if (code == int'(rsti_pkg::CH_SPACE) ||
                        (code >= int'(rsti_pkg::CH_TAB) && code <= int'(rsti_pkg::CH_CR))) begin
                        stop = at + 1;
                    end else if (code == int'(rsti_pkg::CH_PLUS) ||
                                 code == int'(rsti_pkg::CH_MINUS)) begin
                        neg = (code == int'(rsti_pkg::CH_MINUS));
                        stop = at + 1;
                        stage = rsti_pkg::PH_SIGNED;
                    end else begin
                        prefix_step(code, at);
                    end
                end
                rsti_pkg::PH_SIGNED: prefix_step(code, at);
                rsti_pkg::PH_ZERO: begin
                    if (code == int'(rsti_pkg::CH_LX) || code == int'(rsti_pkg::CH_UX)) begin
                        wbase = 32'(rsti_pkg::BASE_HEX);
                        stage = rsti_pkg::PH_DIGITS;
                        stop = at + 1;
                    end else begin
                        if (wbase == 32'(rsti_pkg::BASE_AUTO))
                            wbase = 32'(rsti_pkg::BASE_DEC);
                        stage = rsti_pkg::PH_DIGITS;
                        digit_step(code, at);
                    end
                end
                rsti_pkg::PH_DIGITS: digit_step(code, at);
                default: ;
            endcase
        endfunction

        // called for every accepted character beat
        function void note_char(logic [rsti_pkg::CHAR_W-1:0] c, logic last);
            parse_result_t r;
            if (pos == 0)
                wbase = (radix_reg > rsti_pkg::BASE_MAX) ? 32'(rsti_pkg::BASE_MAX) :
                                                           32'(radix_reg);
            if (pos < rsti_pkg::MAX_LEN) begin
                take_char(int'(c), pos);
                pos++;
            end
            if (last) begin
                r.value = neg ? (rsti_pkg::VALUE_W'(0) - mag) : mag;
                r.offset = rsti_pkg::OFFSET_W'(stop);
                r.overflow = sat;
                pending_values.push_back(r);
                clear_string();
            end
        endfunction

        task check_value(logic signed [rsti_pkg::VALUE_W-1:0] v,
                         logic [rsti_pkg::OFFSET_W-1:0] off, logic ovf);
            parse_result_t e;
            if (pending_values.size() == 0) begin
                report($sformatf("unexpected result beat, value %0d offset %0d", v, off));
                return;
            end
            e = pending_values.pop_front();
            if (v !== e.value)
                report($sformatf("value %0d, predicted %0d", v, e.value));
            if (off !== e.offset)
                report($sformatf("stop_offset %0d, predicted %0d", off, e.offset));
            if (ovf !== e.overflow)
                report($sformatf("overflow %b, predicted %b", ovf, e.overflow));
        endtask
    endclass

    logic                                aclk;
    logic                                aresetn = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [rsti_pkg::BASE_W-1:0]         cfg_radix = '0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [rsti_pkg::CHAR_W-1:0]         s_char_code = '0;
    logic                                s_is_last = 1'b0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [rsti_pkg::VALUE_W-1:0] m_value;
    logic [rsti_pkg::OFFSET_W-1:0]       m_stop_offset;
    logic                                m_overflow;

    parse_scoreboard             sb = new();
    logic [rsti_pkg::CHAR_W-1:0] text_q[$];
    int unsigned                 sent_chars = 0;
    int unsigned                 send_idle_pct = 37;
    int unsigned                 recv_idle_pct = 84;
    logic [rsti_pkg::BASE_W-1:0] radix_corners [8] = '{rsti_pkg::BASE_AUTO, 6'd1, 6'd2,
                                                       rsti_pkg::BASE_DEC, rsti_pkg::BASE_HEX,
                                                       rsti_pkg::BASE_MAX, 6'd37, 6'd63};

    radix_string_to_integer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_radix     (cfg_radix),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_stop_offset (m_stop_offset),
        .m_overflow    (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random back-pressure, check every accepted beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_value(m_value, m_stop_offset, m_overflow);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [rsti_pkg::CHAR_W-1:0] digit_char(int unsigned d);
        if (d < 10)
            return rsti_pkg::CH_ZERO + rsti_pkg::CHAR_W'(d);
        return ($urandom_range(1) ? rsti_pkg::CH_LA : rsti_pkg::CH_UA) +
               rsti_pkg::CHAR_W'(d - 10);
    endfunction

    function automatic void load_text(string s);
        text_q.delete();
        foreach (s[i])
            text_q.push_back(s[i]);
    endfunction

    // mostly well-formed numbers for the current radix, some raw noise
    function automatic void make_string();
        int unsigned eff, db, n, pick;
        bit          hex;
        text_q.delete();
        hex = 1'b0;
        eff = (sb.radix_reg > rsti_pkg::BASE_MAX) ? 32'(rsti_pkg::BASE_MAX) :
                                                    32'(sb.radix_reg);
        if ($urandom_range(99) < 18) begin
            repeat ($urandom_range(1, 8))
                text_q.push_back(rsti_pkg::CHAR_W'($urandom_range(255)));
            return;
        end
        if ($urandom_range(1)) begin
            repeat ($urandom_range(1, 3)) begin
                pick = $urandom_range(5);
                text_q.push_back(pick == 0 ? rsti_pkg::CH_SPACE :
                                 rsti_pkg::CH_TAB + rsti_pkg::CHAR_W'(pick - 1));
            end
        end
        pick = $urandom_range(3);
        if (pick == 0)
            text_q.push_back(rsti_pkg::CH_PLUS);
        else if (pick == 1)
            text_q.push_back(rsti_pkg::CH_MINUS);
        if ((eff == 32'(rsti_pkg::BASE_AUTO) || eff == 32'(rsti_pkg::BASE_HEX)) &&
            $urandom_range(2) == 0) begin
            text_q.push_back(rsti_pkg::CH_ZERO);
            text_q.push_back($urandom_range(1) ? rsti_pkg::CH_LX : rsti_pkg::CH_UX);
            hex = 1'b1;
        end
        db = (eff == 32'(rsti_pkg::BASE_AUTO)) ?
             (hex ? 32'(rsti_pkg::BASE_HEX) : 32'(rsti_pkg::BASE_DEC)) : eff;
        if (db == 32'(rsti_pkg::BASE_HEX) && $urandom_range(19) == 0) begin
            // right at the saturation boundary, just inside or just past it
            pick = $urandom_range(1);
            text_q.push_back(pick ? digit_char(8) : digit_char(7));
            repeat (15)
                text_q.push_back(pick ? rsti_pkg::CH_ZERO : digit_char(15));
        end else begin
            pick = $urandom_range(99);
            n = (pick < 8) ? 0 : (pick < 88) ? $urandom_range(1, 8) : $urandom_range(9, 70);
            repeat (n)
                text_q.push_back(digit_char($urandom_range(db - 1)));
        end
        if ($urandom_range(1)) begin
            repeat ($urandom_range(1, 3))
                text_q.push_back(rsti_pkg::CHAR_W'($urandom_range(255)));
        end
        if (text_q.size() == 0)
            text_q.push_back(rsti_pkg::CHAR_W'($urandom_range(255)));
    endfunction

    // valid stays up across back-to-back beats; it only drops for a gap
    task automatic send_char(input logic [rsti_pkg::CHAR_W-1:0] c, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= c;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_char(c, last);
        sent_chars++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic write_radix(input logic [rsti_pkg::BASE_W-1:0] r);
        s_valid <= 1'b0;
        while (sb.pending_values.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_radix <= r;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.set_radix(r);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned seg_start;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // auto radix straight out of reset
        load_text(" -0xfF");
        send_text();
        load_text("0X");
        send_text();
        load_text("0");
        send_text();
        load_text("-0");
        send_text();
        load_text("\t");
        text_q.push_back(8'h00);
        send_text();
        text_q.delete();
        text_q.push_back(8'hFF);
        send_text();
        write_radix(6'd1);
        load_text("01");
        send_text();
        // anything above 36 behaves as 36
        write_radix(6'd63);
        load_text("zZ");
        send_text();
        write_radix(6'd2);
        load_text("+102");
        send_text();

        for (int seg = 0; seg < 15; seg++) begin
            send_idle_pct = (seg < 5) ? 37 : (seg < 10) ? 84 : 0;
            recv_idle_pct = (seg < 5) ? 84 : (seg < 10) ? 37 : 0;
            write_radix(seg < 8 ? radix_corners[seg] :
                        rsti_pkg::BASE_W'($urandom_range(63)));
            seg_start = sent_chars;
            while (sent_chars - seg_start < 110) begin
                make_string();
                send_text();
            end
        end

        s_valid <= 1'b0;
        while (sb.pending_values.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("radix_string_to_integer_test: done, clean");
        else
            $display("radix_string_to_integer_test: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("radix_string_to_integer_test: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/rsti_pkg.sv
src/rsti_front.sv
src/rsti_fifo.sv
src/rsti_back.sv
src/radix_string_to_integer.sv
dv/radix_string_to_integer_test.sv
